// ===== sv/rrfm_pkg.sv =====
package rrfm_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 8;

  // Input tdata field offsets (lowest bit of each field)
  localparam int IDX_LSB   = 0;
  localparam int IDX_W     = 6;
  localparam int RX_LSB    = 6;
  localparam int RZ_LSB    = 22;
  localparam int RW_LSB    = 38;
  localparam int RD_LSB    = 54;
  localparam int RC_LSB    = 70;
  localparam int PX_LSB    = 78;
  localparam int PZ_LSB    = 94;
  localparam int COORD_W   = 16;
  localparam int CLASS_W   = 8;

  // Transaction kind carried in s_tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Origin entry: x in bits 15..0, z in bits 31..16
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] x;
  } origin_t;

  // Extent entry: width 15..0, depth 31..16, class 39..32
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [COORD_W-1:0] depth;
    logic [COORD_W-1:0] width;
  } extent_t;

  // Per-entry compare status
  typedef struct packed {
    logic term;
    logic hit;
  } match_stat_t;

endpackage

// ===== sv/rrfm_ram.sv =====
module rrfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rrfm_match.sv =====
module rrfm_match (
  input  logic signed [rrfm_pkg::COORD_W-1:0] px,
  input  logic signed [rrfm_pkg::COORD_W-1:0] pz,
  input  rrfm_pkg::origin_t                   org,
  input  rrfm_pkg::extent_t                   ext,
  output rrfm_pkg::match_stat_t               stat
);

  logic [rrfm_pkg::COORD_W:0] dx;
  logic [rrfm_pkg::COORD_W:0] dz;
  logic                       in_x;
  logic                       in_z;

  // Differences at 17 bits never wrap
  assign dx = {px[rrfm_pkg::COORD_W-1], px} - {org.x[rrfm_pkg::COORD_W-1], org.x};
  assign dz = {pz[rrfm_pkg::COORD_W-1], pz} - {org.z[rrfm_pkg::COORD_W-1], org.z};

  // 0 <= d < extent: sign clear and low bits below extent
  assign in_x = !dx[rrfm_pkg::COORD_W] && (dx[rrfm_pkg::COORD_W-1:0] < ext.width);
  assign in_z = !dz[rrfm_pkg::COORD_W] && (dz[rrfm_pkg::COORD_W-1:0] < ext.depth);

  // Origin x of zero ends the table
  assign stat.term = (org.x == '0);
  assign stat.hit  = !stat.term && in_x && in_z;

endmodule

// ===== sv/rect_region_first_match_lookup.sv =====
// Rectangular region table with first-match point lookup. A transaction with
// s_tuser = write stores one region (origin, extent, class) at entry_index and
// returns nothing; writes to an index at or beyond TABLE_ENTRIES are dropped.
// A transaction with s_tuser = query walks the table from entry 0, stops at
// the first entry whose origin x is zero, and returns the class of the first
// region that contains the point (m_tuser = hit), or class 0 with hit clear.
// A query reads at most TABLE_ENTRIES entries: the walk reads one entry per
// cycle from the region memories. After reset the block runs a clearing pass
// over every entry with s_tready low. A finished result waits in the output
// register while the next transaction is taken.
module rect_region_first_match_lookup #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: entry_index[5:0], region_x[21:6], region_z[37:22],
  //          region_width[53:38], region_depth[69:54], region_class[77:70],
  //          point_x[93:78], point_z[109:94], zero pad[111:110]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rrfm_pkg::IN_TDATA_W-1:0]   s_tdata,
  // s_tuser: operation[0]
  input  logic                              s_tuser,
  // m_tdata: match_class[7:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rrfm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // m_tuser: hit[0]
  output logic                              m_tuser
);

  localparam int AW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = AW + 1;
  localparam int IXW = ((AW > rrfm_pkg::IDX_W) ? AW : rrfm_pkg::IDX_W) + 1;
  localparam logic [CW-1:0]  CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0]  CNT_LAST = CW'(TABLE_ENTRIES - 1);
  localparam logic [IXW-1:0] IDX_END  = IXW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t                                 state;
  logic [CW-1:0]                          addr;
  logic                                   pend;
  logic signed [rrfm_pkg::COORD_W-1:0]    px;
  logic signed [rrfm_pkg::COORD_W-1:0]    pz;
  logic [rrfm_pkg::CLASS_W-1:0]           res_class;
  logic                                   res_hit;

  rrfm_pkg::op_t                          op;
  logic [IXW-1:0]                         idx_ext;
  logic                                   idx_ok;
  logic                                   we;
  logic [AW-1:0]                          waddr;
  rrfm_pkg::origin_t                      org_wdata;
  rrfm_pkg::extent_t                      ext_wdata;
  logic                                   rd_en;
  rrfm_pkg::origin_t                      org_rdata;
  rrfm_pkg::extent_t                      ext_rdata;
  rrfm_pkg::match_stat_t                  stat;

  // Input decode
  assign op      = rrfm_pkg::op_t'(s_tuser);
  assign idx_ext = IXW'(s_tdata[rrfm_pkg::IDX_LSB +: rrfm_pkg::IDX_W]);
  assign idx_ok  = (idx_ext < IDX_END);

  assign s_tready = (state == S_IDLE);

  // Write port: clearing pass or accepted write transaction
  always_comb begin
    if (state == S_CLEAR) begin
      we        = 1'b1;
      waddr     = addr[AW-1:0];
      org_wdata = '0;
      ext_wdata = '0;
    end else begin
      we          = s_tvalid && s_tready && (op == rrfm_pkg::OP_WRITE) && idx_ok;
      waddr       = idx_ext[AW-1:0];
      org_wdata.x = s_tdata[rrfm_pkg::RX_LSB +: rrfm_pkg::COORD_W];
      org_wdata.z = s_tdata[rrfm_pkg::RZ_LSB +: rrfm_pkg::COORD_W];
      ext_wdata.width = s_tdata[rrfm_pkg::RW_LSB +: rrfm_pkg::COORD_W];
      ext_wdata.depth = s_tdata[rrfm_pkg::RD_LSB +: rrfm_pkg::COORD_W];
      ext_wdata.cls   = s_tdata[rrfm_pkg::RC_LSB +: rrfm_pkg::CLASS_W];
    end
  end

  // Walk reads one entry per cycle until the table end
  assign rd_en = (state == S_WALK) && (addr != CNT_END);

  rrfm_ram #(
    .WIDTH($bits(rrfm_pkg::origin_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_origin_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(org_wdata),
    .re   (rd_en),
    .raddr(addr[AW-1:0]),
    .rdata(org_rdata)
  );

  rrfm_ram #(
    .WIDTH($bits(rrfm_pkg::extent_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_extent_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(ext_wdata),
    .re   (rd_en),
    .raddr(addr[AW-1:0]),
    .rdata(ext_rdata)
  );

  rrfm_match u_match (
    .px  (px),
    .pz  (pz),
    .org (org_rdata),
    .ext (ext_rdata),
    .stat(stat)
  );

  // Sequencer: clear, accept, walk, hand result to output register.
  // Writes happen only in clear and idle, so a walk never overlaps a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      addr     <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (addr == CNT_LAST) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid && op == rrfm_pkg::OP_QUERY) begin
            px    <= s_tdata[rrfm_pkg::PX_LSB +: rrfm_pkg::COORD_W];
            pz    <= s_tdata[rrfm_pkg::PZ_LSB +: rrfm_pkg::COORD_W];
            addr  <= '0;
            pend  <= 1'b0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          pend <= rd_en;
          if (rd_en) begin
            addr <= addr + 1'b1;
          end
          if (pend && (stat.term || stat.hit || !rd_en)) begin
            res_class <= stat.hit ? ext_rdata.cls : '0;
            res_hit   <= stat.hit;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          // Output register free or draining this cycle
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_class;
            m_tuser  <= res_hit;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result appears only when a walk has finished
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result without finished walk");

  // Memories are not written while a walk reads them
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !we)
    else $error("memory write during walk");

  // Walk ends once the last entry has been checked
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !rd_en) |=> (state == S_DONE))
    else $error("walk ran past table end");

  // A miss always reports class zero
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("nonzero class without hit");

endmodule
